[hw/rtl/rgb_hsv_color_classifier_unit_macros.svh]
// assertion macros shared by the classifier modules
`ifndef RGB_HSV_COLOR_CLASSIFIER_UNIT_MACROS_SVH
`define RGB_HSV_COLOR_CLASSIFIER_UNIT_MACROS_SVH

// check that holds at every clock edge outside reset
`define RHC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication check, antecedent and consequent given as one property
`define RHC_ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[hw/rtl/rhc_pkg.sv]
// types and constants for the rgb/hsv color classifier
`timescale 1ns / 1ps
package rhc_pkg;

  localparam int CHANNEL_BITS  = 16;
  localparam int HUE_FRAC_BITS = 4;

  localparam int CB    = CHANNEL_BITS;
  // t is below 6 * delta
  localparam int T_W   = CB + 3;
  // t * 60 for class tests
  localparam int H_W   = T_W + 6;
  // t * 60 * 2^frac, hue dividend
  localparam int HN_W  = T_W + 6 + HUE_FRAC_BITS;
  // hue quotient bits: 360 * 2^frac fits
  localparam int HUE_W = 9 + HUE_FRAC_BITS;
  localparam int SAT_W = 9;
  localparam int S_W   = CB + SAT_W;

  // class codes
  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_RED   = 2'd1;
  localparam logic [1:0] CLS_GREEN = 2'd2;
  localparam logic [1:0] CLS_BLUE  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MIN_SAT  = 2'd0;
  localparam logic [1:0] REG_NEAR     = 2'd1;
  localparam logic [1:0] REG_DARK     = 2'd2;

  typedef struct packed {
    logic [8:0]  min_saturation;
    logic [7:0]  near_proximity;
    logic [15:0] dark_ambient;
  } cfg_t;

  // item passed from the front to the divide pipeline
  typedef struct packed {
    logic [HN_W-1:0] hue_num;
    logic [CB-1:0]   delta;
    logic [CB-1:0]   mx;
    logic [1:0]      cls;
  } entry_t;

endpackage

[hw/rtl/rhc_front.sv]
// front: takes an item, finds max/min/sector and the color class
`timescale 1ns / 1ps
module rhc_front
  import rhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] red,
  input  logic [15:0] green,
  input  logic [15:0] blue,
  input  logic [15:0] ambient,
  input  logic [7:0]  proximity,
  input  logic        proximity_ok,
  output logic        f_valid,
  input  logic        f_ready,
  output entry_t      f_entry
);

  logic [CB-1:0]  mx, mn, dl;
  logic [T_W-1:0] t;
  logic [H_W-1:0] h60;
  logic           near, low_sat, dark;
  logic [1:0]     cls;
  entry_t         ent;

  function automatic logic [H_W-1:0] kd(input int k, input logic [CB-1:0] d);
    kd = H_W'(k) * H_W'(d);
  endfunction

  // max, min and hue sector numerator
  always_comb begin
    mx = (red > green) ? red : green;
    mx = (mx > blue) ? mx : blue;
    mn = (red < green) ? red : green;
    mn = (mn < blue) ? mn : blue;
    dl = mx - mn;
    if (dl == '0) begin
      t = '0;
    end else if (red == mx) begin
      if (green >= blue) t = T_W'(green - blue);
      else t = T_W'(6) * T_W'(dl) - T_W'(blue - green);
    end else if (green == mx) begin
      t = T_W'(2) * T_W'(dl) + T_W'(blue) - T_W'(red);
    end else begin
      t = T_W'(4) * T_W'(dl) + T_W'(red) - T_W'(green);
    end
    h60 = H_W'(t) * H_W'(60);
  end

  // class by exact cross-multiplied bounds
  always_comb begin
    near    = proximity_ok && (proximity >= cfg.near_proximity);
    dark    = ambient < cfg.dark_ambient;
    low_sat = (S_W'(dl) << 8) < (S_W'(cfg.min_saturation) * S_W'(mx));
    if (low_sat || (near && dark)) cls = CLS_NONE;
    else if (h60 > kd(85, dl) && h60 < kd(165, dl)) cls = CLS_GREEN;
    else if (h60 > kd(175, dl) && h60 < kd(270, dl)) cls = CLS_BLUE;
    else if (h60 > kd(330, dl) || h60 < kd(30, dl)) cls = CLS_RED;
    else cls = CLS_NONE;
    ent.hue_num = HN_W'(t) * HN_W'(60 * (1 << HUE_FRAC_BITS));
    ent.delta   = dl;
    ent.mx      = mx;
    ent.cls     = cls;
  end

  assign in_ready = !f_valid || f_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_entry <= ent;
    end
  end

endmodule

[hw/rtl/rhc_fifo.sv]
// short queue between front and divide pipeline
`timescale 1ns / 1ps
module rhc_fifo
  import rhc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign full    = count == (PW+1)'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

[hw/rtl/rhc_back.sv]
// back: pipelined restoring dividers for hue and saturation
`timescale 1ns / 1ps
`include "rgb_hsv_color_classifier_unit_macros.svh"
module rhc_back
  import rhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  entry_t            q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HUE_W-1:0]  hue,
  output logic [SAT_W-1:0]  saturation,
  output logic [15:0]       brightness,
  output logic [1:0]        color_class
);

  localparam int STG = HUE_W;

  logic [STG:0]      v;
  logic [CB-1:0]     rh [STG+1];
  logic [HUE_W-1:0]  nh [STG+1];
  logic [HUE_W-1:0]  qh [STG+1];
  logic [CB-1:0]     rs [STG+1];
  logic [SAT_W-1:0]  ns [STG+1];
  logic [SAT_W-1:0]  qs [STG+1];
  logic [CB-1:0]     dl [STG+1];
  logic [CB-1:0]     mx [STG+1];
  logic [1:0]        cl [STG+1];
  logic              advance;
  logic [CB:0]       th [STG];
  logic [CB:0]       ts [STG];

  assign advance = !v[STG] || out_ready;
  assign q_pop   = advance;

  // one hue quotient bit per stage, a saturation bit only in the first SAT_W stages
  always_comb begin
    for (int k = 0; k < STG; k++) begin
      th[k] = {rh[k], nh[k][HUE_W-1]};
      ts[k] = {rs[k], ns[k][SAT_W-1]};
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (advance) begin
      v <= {v[STG-1:0], !q_empty};
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (advance) begin
      rh[0] <= q_head.hue_num[HN_W-1:HUE_W];
      nh[0] <= q_head.hue_num[HUE_W-1:0];
      qh[0] <= '0;
      rs[0] <= q_head.delta >> 1;
      ns[0] <= {q_head.delta[0], {(SAT_W-1){1'b0}}};
      qs[0] <= '0;
      dl[0] <= q_head.delta;
      mx[0] <= q_head.mx;
      cl[0] <= q_head.cls;
      for (int k = 0; k < STG; k++) begin
        dl[k+1] <= dl[k];
        mx[k+1] <= mx[k];
        cl[k+1] <= cl[k];
        nh[k+1] <= nh[k] << 1;
        if (th[k] >= {1'b0, dl[k]}) begin
          rh[k+1] <= CB'(th[k] - {1'b0, dl[k]});
          qh[k+1] <= {qh[k][HUE_W-2:0], 1'b1};
        end else begin
          rh[k+1] <= th[k][CB-1:0];
          qh[k+1] <= {qh[k][HUE_W-2:0], 1'b0};
        end
        if (k < SAT_W) begin
          ns[k+1] <= ns[k] << 1;
          if (ts[k] >= {1'b0, mx[k]}) begin
            rs[k+1] <= CB'(ts[k] - {1'b0, mx[k]});
            qs[k+1] <= {qs[k][SAT_W-2:0], 1'b1};
          end else begin
            rs[k+1] <= ts[k][CB-1:0];
            qs[k+1] <= {qs[k][SAT_W-2:0], 1'b0};
          end
        end else begin
          ns[k+1] <= ns[k];
          rs[k+1] <= rs[k];
          qs[k+1] <= qs[k];
        end
      end
    end
  end

  // gray input gives zero hue and saturation
  assign out_valid   = v[STG];
  assign hue         = (dl[STG] == '0) ? '0 : qh[STG];
  assign saturation  = (dl[STG] == '0) ? '0 : qs[STG];
  assign brightness  = mx[STG];
  assign color_class = cl[STG];

  `RHC_ASSERT_IMPL(a_stall_freeze, (v[STG] && !out_ready) |=> (v[STG] && $stable(qh[STG])), "pipeline moved under stall")
  `RHC_ASSERT_IMPL(a_sat_range, v[STG] |-> (saturation <= SAT_W'(256)), "saturation above one")
  `RHC_ASSERT_IMPL(a_hue_range, v[STG] |-> (hue < HUE_W'(360 << HUE_FRAC_BITS)), "hue out of range")

endmodule

[hw/rtl/rgb_hsv_color_classifier_unit.sv]
// top level of the rgb/hsv color classifier
//
// Input channel (in_valid/in_ready): one reading per item, red, green, blue,
// ambient, proximity and proximity_ok. Output channel (out_valid/out_ready):
// one result per item, hue in 1/16 degree, saturation in Q8, brightness
// (max channel) and color_class (0 none, 1 red, 2 green, 3 blue).
// Configuration: cfg_we with cfg_index 0 min_saturation, 1 near_proximity,
// 2 dark_ambient, data in the low bits of cfg_data; write only while idle.
// Throughput is one item per clock unless out_ready stalls the output. An
// accepted item passes in order through one front register, one queue
// slot, a load stage, then 13 divide stages that each yield one hue
// quotient bit (and the first 9 one saturation bit).
// When out_ready is low with a result waiting, the whole divide pipeline
// holds; the 4-entry queue and the front register take items until full,
// then in_ready drops. Reset empties the pipeline and queue and loads the
// register defaults: min_saturation 128, near_proximity 88, dark_ambient 200.
`timescale 1ns / 1ps
module rgb_hsv_color_classifier_unit
  import rhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] red,
  input  logic [15:0] green,
  input  logic [15:0] blue,
  input  logic [15:0] ambient,
  input  logic [7:0]  proximity,
  input  logic        proximity_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] hue,
  output logic [8:0]  saturation,
  output logic [15:0] brightness,
  output logic [1:0]  color_class
);

  cfg_t   cfg;
  logic   f_valid, q_full, q_empty, q_pop;
  entry_t f_entry, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_saturation <= 9'd128;
      cfg.near_proximity <= 8'd88;
      cfg.dark_ambient   <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_SAT: cfg.min_saturation <= cfg_data[8:0];
        REG_NEAR:    cfg.near_proximity <= cfg_data[7:0];
        REG_DARK:    cfg.dark_ambient   <= cfg_data;
        default:     ;
      endcase
    end
  end

  rhc_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready),
    .red(red), .green(green), .blue(blue), .ambient(ambient),
    .proximity(proximity), .proximity_ok(proximity_ok),
    .f_valid(f_valid), .f_ready(!q_full), .f_entry(f_entry)
  );

  rhc_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(f_valid), .push_entry(f_entry), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  rhc_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .hue(hue), .saturation(saturation), .brightness(brightness),
    .color_class(color_class)
  );

endmodule
